@@ design/cwsc_pkg.sv @@
// Package for the CRC word stream checker: queue entry type, polynomial
// constants and the 16-bit word feed function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cwsc_pkg;

	localparam int WORD_BITS = 16;
	localparam int CRC_BITS  = 32;

	localparam logic [15:0] POLY16       = 16'h8005;
	localparam logic [31:0] POLY32       = 32'h04C1_1DB7;
	localparam logic [15:0] PAYLOAD_MASK = 16'h0FFF;

	localparam logic CFG_CRC32_MODE  = 1'b0;
	localparam logic CFG_SAMPLE_MODE = 1'b1;

	// One queued operation: up to two words fed in order, optional result.
	typedef struct packed {
		logic [1:0]           feed_cnt;
		logic [WORD_BITS-1:0] word_a;
		logic [WORD_BITS-1:0] word_b;
		logic                 emit;
	} op_t;

	typedef struct packed {
		logic push;
		op_t  op;
	} push_t;

	typedef struct packed {
		logic not_empty;
		op_t  op;
	} head_t;

	// Shift one word into the remainder, msb first, under the selected width.
	function automatic logic [CRC_BITS-1:0] crc_feed(
		input logic [CRC_BITS-1:0]  r_in,
		input logic [WORD_BITS-1:0] w,
		input logic                 crc32
	);
		logic [CRC_BITS-1:0] r;
		logic                fb;
		r = crc32 ? r_in : {16'h0000, r_in[15:0]};
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			fb = crc32 ? r[31] : r[15];
			r  = {r[30:0], w[i]};
			if (!crc32) begin
				r[31:16] = 16'h0000;
			end
			if (fb) begin
				r = r ^ (crc32 ? POLY32 : {16'h0000, POLY16});
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ design/crc_word_stream_checker.sv @@
// Top level of the CRC word stream checker: configuration registers, front
// end, operation queue and back end. Uses cwsc_pkg and the cwsc_* modules.
//
// Usage:
//  - Message words enter on data_valid / data_stall with data_word and
//    last_word; a word is taken at an edge with data_valid high and
//    data_stall low. Words go in msb first into a zero-started remainder.
//  - One result per message, on its last word: remainder and
//    remainder_zero on result_valid / result_stall.
//  - Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data;
//    index 0 is crc32_mode, index 1 is sample_mode. cfg_ready is always
//    high. Write only while the block is idle.
//  - Throughput: one word per cycle while data_stall is low. The limit is the
//    running-remainder update in the back end, which folds up to 32 bits at once.
//  - Result path: a last word passes through the queue, the contribution
//    stage and the result register before its result shows.
//  - Stall: a stalled result holds; the back end halts, the two-entry queue
//    fills, then data_stall rises.
//  - Reset clears the modes, the held word, the remainder and the queue.
`timescale 1ns / 1ps
`default_nettype none

module crc_word_stream_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic                          cfg_index,
	input  wire logic                          cfg_data,
	input  wire logic                          data_valid,
	output logic                               data_stall,
	input  wire logic [cwsc_pkg::WORD_BITS-1:0] data_word,
	input  wire logic                          last_word,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic [cwsc_pkg::CRC_BITS-1:0]      remainder,
	output logic                               remainder_zero
);

	logic            crc32_mode_q;
	logic            sample_mode_q;
	logic            queue_full;
	logic            pop;
	cwsc_pkg::push_t push;
	cwsc_pkg::head_t head;

	assign cfg_ready  = 1'b1;
	assign data_stall = queue_full;

	// Configuration registers: the user must write only while idle; the block itself does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc32_mode_q  <= 1'b0;
			sample_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cwsc_pkg::CFG_CRC32_MODE:  crc32_mode_q  <= cfg_data;
				cwsc_pkg::CFG_SAMPLE_MODE: sample_mode_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front: hold back one word in sample mode, classify into feed operations.
	cwsc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_mode (sample_mode_q),
		.data_valid  (data_valid),
		.data_word   (data_word),
		.last_word   (last_word),
		.queue_full  (queue_full),
		.push        (push)
	);

	// Queue: lets the front keep taking words while the back waits.
	cwsc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (queue_full),
		.head   (head)
	);

	// Back: fold words into the remainder, present results.
	cwsc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.crc32_mode     (crc32_mode_q),
		.head           (head),
		.pop            (pop),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.remainder      (remainder),
		.remainder_zero (remainder_zero)
	);

endmodule

`default_nettype wire

@@ design/cwsc_front.sv @@
// Front end: accepts message words, holds one word back in sample mode and
// turns the words into queued feed operations. Uses cwsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cwsc_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          sample_mode,
	input  wire logic                          data_valid,
	input  wire logic [cwsc_pkg::WORD_BITS-1:0] data_word,
	input  wire logic                          last_word,
	input  wire logic                          queue_full,
	output cwsc_pkg::push_t                    push
);

	logic [cwsc_pkg::WORD_BITS-1:0] held_word_q;
	logic                           held_valid_q;
	logic                           accept;
	cwsc_pkg::op_t                  op;

	assign accept = data_valid && !queue_full;

	always_comb begin
		op.feed_cnt = 2'd0;
		op.word_a   = data_word;
		op.word_b   = data_word;
		op.emit     = last_word;
		if (sample_mode && !last_word) begin
			// flush the older held word as payload, keep the new one back
			op.feed_cnt = held_valid_q ? 2'd1 : 2'd0;
			op.word_a   = held_word_q & cwsc_pkg::PAYLOAD_MASK;
		end else if (sample_mode) begin
			// trailing pair goes in swapped
			op.feed_cnt = held_valid_q ? 2'd2 : 2'd1;
			op.word_a   = data_word;
			op.word_b   = held_word_q;
		end else if (held_valid_q) begin
			op.feed_cnt = 2'd2;
			op.word_a   = held_word_q & cwsc_pkg::PAYLOAD_MASK;
			op.word_b   = data_word;
		end else begin
			op.feed_cnt = 2'd1;
		end
	end

	assign push.op   = op;
	assign push.push = accept && (op.feed_cnt != 2'd0 || op.emit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			held_word_q  <= '0;
		end else if (accept) begin
			if (sample_mode && !last_word) begin
				held_valid_q <= 1'b1;
				held_word_q  <= data_word;
			end else begin
				held_valid_q <= 1'b0;
				held_word_q  <= '0;
			end
		end
	end

endmodule

`default_nettype wire

@@ design/cwsc_fifo.sv @@
// Two-entry queue of feed operations between front and back end.
// Uses cwsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cwsc_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cwsc_pkg::push_t  push,
	input  wire logic             pop,
	output logic                  full,
	output cwsc_pkg::head_t       head
);

	cwsc_pkg::op_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          do_push;
	logic          do_pop;

	assign full           = (count_q == 2'd2);
	assign head.not_empty = (count_q != 2'd0);
	assign head.op        = entry_q[rd_ptr_q];
	assign do_push        = push.push && !full;
	assign do_pop         = pop && head.not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

@@ design/cwsc_back.sv @@
// Back end: computes the word contribution from a zero remainder, folds it
// into the running remainder and drives the result register. Uses cwsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cwsc_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          crc32_mode,
	input  wire cwsc_pkg::head_t               head,
	output logic                               pop,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic [cwsc_pkg::CRC_BITS-1:0]      remainder,
	output logic                               remainder_zero
);

	logic                          advance;
	logic [cwsc_pkg::CRC_BITS-1:0] c1;
	logic [cwsc_pkg::CRC_BITS-1:0] c2;
	logic [cwsc_pkg::CRC_BITS-1:0] contrib;
	logic [cwsc_pkg::CRC_BITS-1:0] sh1;
	logic [cwsc_pkg::CRC_BITS-1:0] sh2;
	logic [cwsc_pkg::CRC_BITS-1:0] acc_next;
	logic [cwsc_pkg::CRC_BITS-1:0] rem_out;

	logic                          valid_s1;
	logic [1:0]                    cnt_s1;
	logic                          emit_s1;
	logic [cwsc_pkg::CRC_BITS-1:0] contrib_s1;
	logic [cwsc_pkg::CRC_BITS-1:0] acc_q;
	logic                          out_valid_q;
	logic [cwsc_pkg::CRC_BITS-1:0] remainder_q;
	logic                          zero_q;

	assign advance = !(out_valid_q && result_stall);
	assign pop     = advance && head.not_empty;

	// Contribution of the words alone: the feed is linear in remainder and word.
	assign c1 = cwsc_pkg::crc_feed('0, head.op.word_a, crc32_mode);
	assign c2 = cwsc_pkg::crc_feed(c1, head.op.word_b, crc32_mode);
	always_comb begin
		case (head.op.feed_cnt)
			2'd2:    contrib = c2;
			2'd1:    contrib = c1;
			default: contrib = '0;
		endcase
	end

	// Advance the running remainder by 16 or 32 zero bits.
	assign sh1 = cwsc_pkg::crc_feed(acc_q, '0, crc32_mode);
	assign sh2 = cwsc_pkg::crc_feed(sh1, '0, crc32_mode);
	always_comb begin
		case (cnt_s1)
			2'd2:    acc_next = sh2 ^ contrib_s1;
			2'd1:    acc_next = sh1 ^ contrib_s1;
			default: acc_next = acc_q;
		endcase
	end
	assign rem_out = crc32_mode ? acc_next : {16'h0000, acc_next[15:0]};

	always_ff @(posedge clk) begin
		if (advance) begin
			cnt_s1      <= head.op.feed_cnt;
			emit_s1     <= head.op.emit;
			contrib_s1  <= contrib;
			remainder_q <= rem_out;
			zero_q      <= (rem_out == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			acc_q       <= '0;
		end else if (advance) begin
			valid_s1    <= head.not_empty;
			out_valid_q <= valid_s1 && emit_s1;
			if (valid_s1) begin
				acc_q <= emit_s1 ? '0 : acc_next;
			end
		end
	end

	assign result_valid   = out_valid_q;
	assign remainder      = remainder_q;
	assign remainder_zero = zero_q;

endmodule

`default_nettype wire

@@ design/cwsc_checker.sv @@
// Port-level checks for the CRC word stream checker, bound to the top level.
// Depends on crc_word_stream_checker and cwsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cwsc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cfg_valid,
	input wire logic        cfg_ready,
	input wire logic        cfg_index,
	input wire logic        cfg_data,
	input wire logic        result_valid,
	input wire logic        result_stall,
	input wire logic [31:0] remainder,
	input wire logic        remainder_zero
);

	logic crc32_mode_q;

	// Track the width mode as written through the configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc32_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready && cfg_index == cwsc_pkg::CFG_CRC32_MODE) begin
			crc32_mode_q <= cfg_data;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			result_valid && $stable(remainder) && $stable(remainder_zero))
		else $error("stalled result changed");

	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (remainder_zero == (remainder == 32'h0)))
		else $error("zero flag disagrees with remainder");

	a_crc16_width: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !crc32_mode_q |-> remainder[31:16] == 16'h0000)
		else $error("upper remainder bits set in 16-bit mode");

endmodule

bind crc_word_stream_checker cwsc_checker u_cwsc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.cfg_valid      (cfg_valid),
	.cfg_ready      (cfg_ready),
	.cfg_index      (cfg_index),
	.cfg_data       (cfg_data),
	.result_valid   (result_valid),
	.result_stall   (result_stall),
	.remainder      (remainder),
	.remainder_zero (remainder_zero)
);

`default_nettype wire
